[rtl/core/ggrm_pkg.sv]
package ggrm_pkg;

    // Default grid size
    localparam int DEF_GRID_WIDTH  = 64;
    localparam int DEF_GRID_HEIGHT = 64;

    // Item field widths
    localparam int OP_W    = 2;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int TYPE_W  = 4;
    localparam int MODEL_W = 7;
    localparam int SIZE_W  = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // Reset content of every cell
    localparam logic [TYPE_W-1:0]  RESET_TYPE  = 4'd1;
    localparam logic [MODEL_W-1:0] RESET_MODEL = 7'd0;

    // Cursor moves
    localparam logic [2:0] CUR_HOLD   = 3'd0;
    localparam logic [2:0] CUR_SCAN   = 3'd1;  // load from scan position
    localparam logic [2:0] CUR_NEXT   = 3'd2;  // raster step with row wrap
    localparam logic [2:0] CUR_RIGHT  = 3'd3;  // one column right
    localparam logic [2:0] CUR_DOWN   = 3'd4;  // next row, left column
    localparam logic [2:0] CUR_CORNER = 3'd5;  // top left of rectangle
    localparam logic [2:0] CUR_BELOW  = 3'd6;  // row under top, left column

    typedef struct packed {
        logic [2:0] cur_op;
        logic       accept;
        logic       cell_wr;
        logic       hit_cap;
        logic       w_inc;
        logic       h_init;
        logic       h_inc;
        logic       vis_set;
        logic       sweep_vis;
        logic       sweep_cell;
        logic       scan_rewind;
        logic       scan_after_hit;
        logic       res_load;
        logic       res_found;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic match;
        logic x_last;
        logic x_end;
        logic y_last;
        logic y_end;
        logic top_last;
        logic sweep_last;
        logic scan_end;
        logic out_free;
    } t_status;

endpackage

[rtl/core/grid_greedy_rectangle_merge.sv]
// Greedy rectangle merger over a GRID_HEIGHT x GRID_WIDTH labeled grid. Each item
// is a cell write, a find-next-rectangle request, or a clear of the visited marks,
// and gives exactly one result item. Items are handled one at a time by a state
// machine over single-port cell memories with registered reads, so each cell probe
// takes a read state and then a check state. A write or unused code goes on to its
// result, a clear resets the visited marks of all grid cells, and a find probes
// each cell scanned, each cell of the rightward run and each cell checked in the
// rows below, then marks each cell of the rectangle. After reset a clearing pass
// over every cell loads the default cells; no item is taken then.
// A finished result sits in an output register while the next item is taken.
module grid_greedy_rectangle_merge #(
    parameter int GRID_WIDTH  = ggrm_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = ggrm_pkg::DEF_GRID_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ggrm_pkg::OP_W-1:0]     i_operation,
    input  logic [ggrm_pkg::ROW_W-1:0]    i_cell_row,
    input  logic [ggrm_pkg::COL_W-1:0]    i_cell_col,
    input  logic [ggrm_pkg::TYPE_W-1:0]   i_cell_type,
    input  logic [ggrm_pkg::MODEL_W-1:0]  i_cell_model,
    input  logic [ggrm_pkg::TYPE_W-1:0]   i_target_type,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [ggrm_pkg::ROW_W-1:0]    o_rect_row,
    output logic [ggrm_pkg::COL_W-1:0]    o_rect_col,
    output logic [ggrm_pkg::SIZE_W-1:0]   o_rect_width,
    output logic [ggrm_pkg::SIZE_W-1:0]   o_rect_height,
    output logic [ggrm_pkg::MODEL_W-1:0]  o_rect_model
);

    ggrm_pkg::t_cmd    w_cmd;
    ggrm_pkg::t_status w_status;

    ggrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_stall     (o_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ggrm_dpath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cell_row    (i_cell_row),
        .i_cell_col    (i_cell_col),
        .i_cell_type   (i_cell_type),
        .i_cell_model  (i_cell_model),
        .i_target_type (i_target_type),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_rect_row    (o_rect_row),
        .o_rect_col    (o_rect_col),
        .o_rect_width  (o_rect_width),
        .o_rect_height (o_rect_height),
        .o_rect_model  (o_rect_model)
    );

    // A result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_load |-> !(o_valid && i_stall))
        else $error("result loaded over a waiting result");

    // No item is taken during a sweep of the memories
    a_sweep_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.sweep_vis |-> o_stall)
        else $error("input open during sweep");

    // A miss result carries all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_rect_width == '0 && o_rect_height == '0 &&
                                   o_rect_row == '0 && o_rect_col == '0 &&
                                   o_rect_model == '0))
        else $error("miss result with nonzero fields");

endmodule

[rtl/core/ggrm_dpath.sv]
module ggrm_dpath #(
    parameter int GRID_WIDTH  = ggrm_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = ggrm_pkg::DEF_GRID_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ggrm_pkg::t_cmd                    i_cmd,
    output ggrm_pkg::t_status                 o_status,
    input  logic [ggrm_pkg::ROW_W-1:0]        i_cell_row,
    input  logic [ggrm_pkg::COL_W-1:0]        i_cell_col,
    input  logic [ggrm_pkg::TYPE_W-1:0]       i_cell_type,
    input  logic [ggrm_pkg::MODEL_W-1:0]      i_cell_model,
    input  logic [ggrm_pkg::TYPE_W-1:0]       i_target_type,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic                              o_found,
    output logic [ggrm_pkg::ROW_W-1:0]        o_rect_row,
    output logic [ggrm_pkg::COL_W-1:0]        o_rect_col,
    output logic [ggrm_pkg::SIZE_W-1:0]       o_rect_width,
    output logic [ggrm_pkg::SIZE_W-1:0]       o_rect_height,
    output logic [ggrm_pkg::MODEL_W-1:0]      o_rect_model
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int RB    = $clog2(GRID_HEIGHT);
    localparam int CB    = $clog2(GRID_WIDTH);
    localparam int WB    = $clog2(GRID_WIDTH + 1);
    localparam int HB    = $clog2(GRID_HEIGHT + 1);
    localparam int CW    = ggrm_pkg::TYPE_W + ggrm_pkg::MODEL_W;

    // Cell memories
    logic [CW-1:0] r_cell_mem [CELLS];
    logic          r_vis_mem  [CELLS];
    logic [CW-1:0] r_rd_cell;
    logic          r_rd_vis;

    // Scan position, cursor and rectangle
    logic [HB-1:0] r_scan_row;
    logic [CB-1:0] r_scan_col;
    logic [RB-1:0] r_y;
    logic [CB-1:0] r_x;
    logic [RB-1:0] r_top;
    logic [CB-1:0] r_left;
    logic [WB-1:0] r_w;
    logic [HB-1:0] r_h;
    logic [ggrm_pkg::MODEL_W-1:0] r_model;
    logic [ggrm_pkg::TYPE_W-1:0]  r_target;
    logic [AW-1:0] r_clr;

    // Result register
    logic                          r_o_valid;
    logic                          r_o_found;
    logic [ggrm_pkg::ROW_W-1:0]    r_o_row;
    logic [ggrm_pkg::COL_W-1:0]    r_o_col;
    logic [ggrm_pkg::SIZE_W-1:0]   r_o_width;
    logic [ggrm_pkg::SIZE_W-1:0]   r_o_height;
    logic [ggrm_pkg::MODEL_W-1:0]  r_o_model;

    logic          in_range;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] addr;
    logic          cell_we;
    logic [CW-1:0] cell_wd;
    logic          vis_we;
    logic          vis_wd;
    logic [ggrm_pkg::TYPE_W-1:0]  rd_type;
    logic [ggrm_pkg::MODEL_W-1:0] rd_model;

    // Address selection
    always_comb begin
        in_range = (int'(i_cell_row) < GRID_HEIGHT) && (int'(i_cell_col) < GRID_WIDTH);
        in_addr  = AW'(int'(RB'(i_cell_row)) * GRID_WIDTH + int'(CB'(i_cell_col)));
        cur_addr = AW'(int'(r_y) * GRID_WIDTH + int'(r_x));
        if (i_cmd.sweep_vis) begin
            addr = r_clr;
        end else if (i_cmd.accept) begin
            addr = in_addr;
        end else begin
            addr = cur_addr;
        end
        cell_we = i_cmd.sweep_cell || (i_cmd.cell_wr && in_range);
        cell_wd = i_cmd.sweep_cell ? {ggrm_pkg::RESET_TYPE, ggrm_pkg::RESET_MODEL}
                                   : {i_cell_type, i_cell_model};
        vis_we  = i_cmd.sweep_vis || i_cmd.vis_set || (i_cmd.cell_wr && in_range);
        vis_wd  = i_cmd.vis_set;
    end

    // Memory ports, registered read
    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            r_cell_mem[addr] <= cell_wd;
        end
        if (vis_we) begin
            r_vis_mem[addr] <= vis_wd;
        end
        r_rd_cell <= r_cell_mem[addr];
        r_rd_vis  <= r_vis_mem[addr];
    end

    assign rd_type  = r_rd_cell[CW-1 -: ggrm_pkg::TYPE_W];
    assign rd_model = r_rd_cell[ggrm_pkg::MODEL_W-1:0];

    // Status
    always_comb begin
        o_status.hit      = !r_rd_vis && (rd_type == r_target);
        o_status.match    = !r_rd_vis && (rd_type == r_target) && (rd_model == r_model);
        o_status.x_last   = (int'(r_x) == GRID_WIDTH - 1);
        o_status.x_end    = ((WB+1)'(r_x) + (WB+1)'(1)) == ((WB+1)'(r_left) + (WB+1)'(r_w));
        o_status.y_last   = (int'(r_y) == GRID_HEIGHT - 1);
        o_status.y_end    = ((HB+1)'(r_y) + (HB+1)'(1)) == ((HB+1)'(r_top) + (HB+1)'(r_h));
        o_status.top_last = (int'(r_top) == GRID_HEIGHT - 1);
        o_status.sweep_last = (int'(r_clr) == CELLS - 1);
        o_status.scan_end = (int'(r_scan_row) == GRID_HEIGHT);
        o_status.out_free = !r_o_valid || !i_stall;
    end

    // Sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.sweep_vis) begin
            r_clr <= (int'(r_clr) == CELLS - 1) ? '0 : r_clr + AW'(1);
        end
    end

    // Scan position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row <= '0;
            r_scan_col <= '0;
        end else if (i_cmd.scan_rewind) begin
            r_scan_row <= '0;
            r_scan_col <= '0;
        end else if (i_cmd.scan_after_hit) begin
            if (int'(r_left) == GRID_WIDTH - 1) begin
                r_scan_col <= '0;
                r_scan_row <= HB'(r_top) + HB'(1);
            end else begin
                r_scan_col <= r_left + CB'(1);
                r_scan_row <= HB'(r_top);
            end
        end
    end

    // Cursor
    always_ff @(posedge i_clk) begin
        case (i_cmd.cur_op)
            ggrm_pkg::CUR_SCAN: begin
                r_y <= RB'(r_scan_row);
                r_x <= r_scan_col;
            end
            ggrm_pkg::CUR_NEXT: begin
                if (int'(r_x) == GRID_WIDTH - 1) begin
                    r_x <= '0;
                    r_y <= r_y + RB'(1);
                end else begin
                    r_x <= r_x + CB'(1);
                end
            end
            ggrm_pkg::CUR_RIGHT: r_x <= r_x + CB'(1);
            ggrm_pkg::CUR_DOWN: begin
                r_y <= r_y + RB'(1);
                r_x <= r_left;
            end
            ggrm_pkg::CUR_CORNER: begin
                r_y <= r_top;
                r_x <= r_left;
            end
            ggrm_pkg::CUR_BELOW: begin
                r_y <= r_top + RB'(1);
                r_x <= r_left;
            end
            default: begin
                r_y <= r_y;
                r_x <= r_x;
            end
        endcase
    end

    // Rectangle registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_target <= i_target_type;
        end
        if (i_cmd.hit_cap) begin
            r_top   <= r_y;
            r_left  <= r_x;
            r_model <= rd_model;
            r_w     <= WB'(1);
        end else if (i_cmd.w_inc) begin
            r_w <= r_w + WB'(1);
        end
        if (i_cmd.h_init) begin
            r_h <= HB'(1);
        end else if (i_cmd.h_inc) begin
            r_h <= r_h + HB'(1);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_o_found <= i_cmd.res_found;
            if (i_cmd.res_found) begin
                r_o_row    <= ggrm_pkg::ROW_W'(r_top);
                r_o_col    <= ggrm_pkg::COL_W'(r_left);
                r_o_width  <= ggrm_pkg::SIZE_W'(r_w);
                r_o_height <= ggrm_pkg::SIZE_W'(r_h);
                r_o_model  <= r_model;
            end else begin
                r_o_row    <= '0;
                r_o_col    <= '0;
                r_o_width  <= '0;
                r_o_height <= '0;
                r_o_model  <= '0;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_found       = r_o_found;
    assign o_rect_row    = r_o_row;
    assign o_rect_col    = r_o_col;
    assign o_rect_width  = r_o_width;
    assign o_rect_height = r_o_height;
    assign o_rect_model  = r_o_model;

endmodule

[rtl/core/ggrm_ctrl.sv]
module ggrm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ggrm_pkg::OP_W-1:0]   i_operation,
    output logic                        o_stall,
    input  ggrm_pkg::t_status           i_status,
    output ggrm_pkg::t_cmd              o_cmd
);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CLR     = 4'd2;
    localparam logic [3:0] S_SCAN_RD = 4'd3;
    localparam logic [3:0] S_SCAN_CK = 4'd4;
    localparam logic [3:0] S_RUN_RD  = 4'd5;
    localparam logic [3:0] S_RUN_CK  = 4'd6;
    localparam logic [3:0] S_HSTART  = 4'd7;
    localparam logic [3:0] S_ROW_RD  = 4'd8;
    localparam logic [3:0] S_ROW_CK  = 4'd9;
    localparam logic [3:0] S_MARK    = 4'd10;
    localparam logic [3:0] S_HIT     = 4'd11;
    localparam logic [3:0] S_MISS    = 4'd12;
    localparam logic [3:0] S_EMPTY   = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.cur_op = ggrm_pkg::CUR_HOLD;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep_vis  = 1'b1;
                o_cmd.sweep_cell = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_operation)
                        ggrm_pkg::OP_WRITE: begin
                            o_cmd.cell_wr = 1'b1;
                            n_state = S_EMPTY;
                        end
                        ggrm_pkg::OP_FIND: begin
                            o_cmd.cur_op = ggrm_pkg::CUR_SCAN;
                            n_state = i_status.scan_end ? S_MISS : S_SCAN_RD;
                        end
                        ggrm_pkg::OP_CLEAR: n_state = S_CLR;
                        default: n_state = S_EMPTY;
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.sweep_vis   = 1'b1;
                o_cmd.scan_rewind = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_EMPTY;
                end
            end
            S_SCAN_RD: n_state = S_SCAN_CK;
            S_SCAN_CK: begin
                if (i_status.hit) begin
                    o_cmd.hit_cap = 1'b1;
                    if (i_status.x_last) begin
                        n_state = S_HSTART;
                    end else begin
                        o_cmd.cur_op = ggrm_pkg::CUR_RIGHT;
                        n_state = S_RUN_RD;
                    end
                end else if (i_status.x_last && i_status.y_last) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.cur_op = ggrm_pkg::CUR_NEXT;
                    n_state = S_SCAN_RD;
                end
            end
            S_RUN_RD: n_state = S_RUN_CK;
            S_RUN_CK: begin
                if (i_status.match) begin
                    o_cmd.w_inc = 1'b1;
                    if (i_status.x_last) begin
                        n_state = S_HSTART;
                    end else begin
                        o_cmd.cur_op = ggrm_pkg::CUR_RIGHT;
                        n_state = S_RUN_RD;
                    end
                end else begin
                    n_state = S_HSTART;
                end
            end
            S_HSTART: begin
                o_cmd.h_init = 1'b1;
                if (i_status.top_last) begin
                    o_cmd.cur_op = ggrm_pkg::CUR_CORNER;
                    n_state = S_MARK;
                end else begin
                    o_cmd.cur_op = ggrm_pkg::CUR_BELOW;
                    n_state = S_ROW_RD;
                end
            end
            S_ROW_RD: n_state = S_ROW_CK;
            S_ROW_CK: begin
                if (!i_status.match) begin
                    o_cmd.cur_op = ggrm_pkg::CUR_CORNER;
                    n_state = S_MARK;
                end else if (i_status.x_end) begin
                    o_cmd.h_inc = 1'b1;
                    if (i_status.y_last) begin
                        o_cmd.cur_op = ggrm_pkg::CUR_CORNER;
                        n_state = S_MARK;
                    end else begin
                        o_cmd.cur_op = ggrm_pkg::CUR_DOWN;
                        n_state = S_ROW_RD;
                    end
                end else begin
                    o_cmd.cur_op = ggrm_pkg::CUR_RIGHT;
                    n_state = S_ROW_RD;
                end
            end
            S_MARK: begin
                o_cmd.vis_set = 1'b1;
                if (i_status.x_end) begin
                    if (i_status.y_end) begin
                        n_state = S_HIT;
                    end else begin
                        o_cmd.cur_op = ggrm_pkg::CUR_DOWN;
                    end
                end else begin
                    o_cmd.cur_op = ggrm_pkg::CUR_RIGHT;
                end
            end
            S_HIT: begin
                if (i_status.out_free) begin
                    o_cmd.res_load       = 1'b1;
                    o_cmd.res_found      = 1'b1;
                    o_cmd.scan_after_hit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MISS: begin
                if (i_status.out_free) begin
                    o_cmd.res_load    = 1'b1;
                    o_cmd.scan_rewind = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
